>>> design/aligned_bump_allocator_with_block_table_unit_macros.svh
// Assertion macros for the bump allocator
`ifndef ALIGNED_BUMP_ALLOCATOR_WITH_BLOCK_TABLE_UNIT_MACROS_SVH
`define ALIGNED_BUMP_ALLOCATOR_WITH_BLOCK_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define ABBT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ABBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/abbt_pkg.sv
`default_nettype none
package abbt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int ADDR_W = 32;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_INVALID    = 2'd1;
  localparam logic [1:0] ST_NO_SPACE   = 2'd2;
  localparam logic [1:0] ST_TABLE_FULL = 2'd3;

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_BASE   = 2'd1;
  localparam logic [1:0] REG_SIZE   = 2'd2;
  localparam logic [1:0] REG_ALIGN  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_EXEC,
    S_SCAN,
    S_DONE
  } abbt_state_e;

  // control broadcast to every table cell
  typedef struct packed {
    logic              shift;
    logic              wr;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] data;
  } abbt_ctrl_t;

endpackage
`default_nettype wire

>>> design/abbt_cell.sv
`default_nettype none
module abbt_cell (
  input  wire logic                       clk_i,
  input  wire abbt_pkg::abbt_ctrl_t       ctrl_i,
  input  wire logic [abbt_pkg::IDX_W-1:0] cell_idx_i,
  input  wire logic [abbt_pkg::ADDR_W-1:0] right_i,
  output logic      [abbt_pkg::ADDR_W-1:0] entry_o
);
  import abbt_pkg::*;

  logic [ADDR_W-1:0] entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.wr && ctrl_i.idx == cell_idx_i) begin
      entry_d = ctrl_i.data;
    end else if (ctrl_i.shift) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

>>> design/abbt_table.sv
`default_nettype none
module abbt_table (
  input  wire logic                        clk_i,
  input  wire abbt_pkg::abbt_ctrl_t        ctrl_i,
  output logic      [abbt_pkg::ADDR_W-1:0] head_o
);
  import abbt_pkg::*;

  logic [ADDR_W-1:0] entry [TABLE_ENTRIES];

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    logic [ADDR_W-1:0] right;
    // last cell takes the head, closing the ring
    if (g == TABLE_ENTRIES - 1) begin : g_last
      assign right = entry[0];
    end else begin : g_mid
      assign right = entry[g+1];
    end
    abbt_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl_i),
      .cell_idx_i (IDX_W'(g)),
      .right_i    (right),
      .entry_o    (entry[g])
    );
  end

  assign head_o = entry[0];

endmodule
`default_nettype wire

>>> design/aligned_bump_allocator_with_block_table_unit.sv
// channel  | handshake                  | payload
// ---------+----------------------------+--------------------------------------------
// in       | in_valid_i / in_stall_o    | opcode_i, request_size_i, free_address_i
// out      | out_valid_o / out_stall_i  | status_o, granted_address_o, free_bytes_o
// cfg      | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// Allocate, query, clear: after accept the item passes S_CALC (operand round), S_EXEC (fit)
// and S_DONE (output). Free adds an S_SCAN step per live entry before S_DONE (none for a zero
// address or an empty table); the live table rotates one cell per cycle.
// One item at a time; the next item is accepted once the result sits in the output register.
// A stalled output holds the result; the following item waits only at its final step.
// Reset clears control state and loads register defaults; table entries are undefined.
`default_nettype none
`include "aligned_bump_allocator_with_block_table_unit_macros.svh"
module aligned_bump_allocator_with_block_table_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [31:0] request_size_i,
  input  wire logic [31:0] free_address_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [1:0]  status_o,
  output logic      [31:0] granted_address_o,
  output logic      [31:0] free_bytes_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import abbt_pkg::*;

  function automatic logic [32:0] round_up(input logic [31:0] v, input logic [4:0] lg);
    logic [32:0] m;
    m = (33'd1 << lg) - 33'd1;
    return ({1'b0, v} + m) & ~m;
  endfunction

  // configuration registers
  logic        enabled_q;
  logic [31:0] base_q, size_q;
  logic [4:0]  align_q;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      base_q    <= '0;
      size_q    <= '0;
      align_q   <= 5'd4;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ENABLE: enabled_q <= pwdata[0];
        REG_BASE:   base_q    <= pwdata;
        REG_SIZE:   size_q    <= pwdata;
        REG_ALIGN:  align_q   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ENABLE: prdata = {31'd0, enabled_q};
      REG_BASE:   prdata = base_q;
      REG_SIZE:   prdata = size_q;
      REG_ALIGN:  prdata = {27'd0, align_q};
      default:    prdata = '0;
    endcase
  end

  // control state
  abbt_state_e      state_q, state_d;
  logic [31:0]      bump_q, bump_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] step_q, step_d;
  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic             found_q, found_d;
  logic             out_valid_q, out_valid_d;

  // payload
  logic [1:0]  op_q;
  logic [31:0] req_q, addr_q;
  logic [32:0] aoff_q, asz_q;
  logic [1:0]  res_status_q, res_status_d;
  logic [31:0] res_granted_q, res_granted_d;
  logic [31:0] res_freeb_q, res_freeb_d;
  logic [1:0]  out_status_q;
  logic [31:0] out_granted_q, out_freeb_q;

  abbt_ctrl_t       ctrl;
  logic [31:0]      head;
  logic [33:0]      sum;
  logic             fit;
  logic             match;
  logic             out_free;
  logic             in_acc;
  logic [CNT_W-1:0] cnt_m1;

  abbt_table u_table (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .head_o (head)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign sum        = {1'b0, aoff_q} + {1'b0, asz_q};
  assign fit        = (sum <= {2'b00, size_q});
  assign match      = !found_q && (head == addr_q);
  assign cnt_m1     = count_q - CNT_W'(1);

  always_comb begin
    state_d       = state_q;
    bump_d        = bump_q;
    count_d       = count_q;
    step_d        = step_q;
    wr_idx_d      = wr_idx_q;
    found_d       = found_q;
    out_valid_d   = out_valid_q && out_stall_i;
    res_status_d  = res_status_q;
    res_granted_d = res_granted_q;
    res_freeb_d   = res_freeb_q;
    ctrl          = '{shift: 1'b0, wr: 1'b0, idx: wr_idx_q, data: head};

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_CALC;
      end
      S_CALC: state_d = S_EXEC;
      S_EXEC: begin
        res_status_d  = ST_OK;
        res_granted_d = '0;
        res_freeb_d   = '0;
        state_d       = S_DONE;
        if (!enabled_q) begin
          res_status_d = ST_INVALID;
        end else begin
          unique case (op_q)
            OP_ALLOC: begin
              if (!fit) begin
                res_status_d = ST_NO_SPACE;
              end else if (count_q >= CNT_W'(TABLE_ENTRIES)) begin
                res_status_d = ST_TABLE_FULL;
              end else begin
                res_granted_d = base_q + aoff_q[31:0];
                ctrl.wr       = 1'b1;
                ctrl.idx      = count_q[IDX_W-1:0];
                ctrl.data     = res_granted_d;
                count_d       = count_q + CNT_W'(1);
                bump_d        = sum[31:0];
              end
            end
            OP_FREE: begin
              res_status_d = ST_INVALID;
              if (addr_q != '0 && count_q != '0) begin
                step_d   = '0;
                wr_idx_d = cnt_m1[IDX_W-1:0];
                found_d  = 1'b0;
                state_d  = S_SCAN;
              end
            end
            OP_QUERY: begin
              if (aoff_q < {1'b0, size_q}) res_freeb_d = size_q - aoff_q[31:0];
            end
            OP_CLEAR: begin
              bump_d  = '0;
              count_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // rotate the live ring; the first match is dropped and the ring shrinks
        ctrl.shift = 1'b1;
        ctrl.wr    = !match;
        step_d     = step_q + IDX_W'(1);
        if (match) begin
          found_d  = 1'b1;
          wr_idx_d = wr_idx_q - IDX_W'(1);
        end
        if (step_q == cnt_m1[IDX_W-1:0]) begin
          state_d = S_DONE;
          if (found_q || match) begin
            res_status_d = ST_OK;
            count_d      = cnt_m1;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_wr && cfg_idx == REG_ENABLE) begin
      bump_d  = '0;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bump_q      <= '0;
      count_q     <= '0;
      step_q      <= '0;
      wr_idx_q    <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bump_q      <= bump_d;
      count_q     <= count_d;
      step_q      <= step_d;
      wr_idx_q    <= wr_idx_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= opcode_i;
      req_q  <= request_size_i;
      addr_q <= free_address_i;
    end
    if (state_q == S_CALC) begin
      aoff_q <= round_up(bump_q, align_q);
      asz_q  <= round_up(req_q, align_q);
    end
    res_status_q  <= res_status_d;
    res_granted_q <= res_granted_d;
    res_freeb_q   <= res_freeb_d;
    if (state_q == S_DONE && out_free) begin
      out_status_q  <= res_status_q;
      out_granted_q <= res_granted_q;
      out_freeb_q   <= res_freeb_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign granted_address_o = out_granted_q;
  assign free_bytes_o      = out_freeb_q;

  `ABBT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(TABLE_ENTRIES), "live count overflow")
  `ABBT_ASSERT_NOW(a_scan_nonempty, state_q == S_SCAN, count_q != '0, "scan of empty table")
  `ABBT_ASSERT_NOW(a_fail_zero, out_valid_o && status_o != ST_OK,
                   granted_address_o == '0 && free_bytes_o == '0, "failed item carries data")
  `ABBT_ASSERT_NEXT(a_scan_keeps_count, state_q == S_SCAN && state_d == S_SCAN && !cfg_wr,
                    count_q == $past(count_q), "count moved during scan")

endmodule
`default_nettype wire
